### design/rgbds_pkg.sv
// Package for the RGBA8 2x2 box downsampler: sizes, register codes and the
// types shared by the scan, reduce and top-level modules. No dependencies.
package rgbds_pkg;

  localparam int MAX_SOURCE_WIDTH = 4096;
  localparam int HEIGHT_LIMIT     = 4096;
  localparam int REG_W            = 13;
  localparam int REG_INDEX_W      = 1;
  localparam int COL_W            = $clog2(MAX_SOURCE_WIDTH);
  localparam int WID_W            = COL_W + 1;
  localparam int ROW_W            = $clog2(HEIGHT_LIMIT);
  localparam int HGT_W            = ROW_W + 1;
  localparam int LINE_DEPTH       = MAX_SOURCE_WIDTH / 2;
  localparam int ADDR_W           = $clog2(LINE_DEPTH);

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_SOURCE_WIDTH  = 1'b0,
    REG_SOURCE_HEIGHT = 1'b1
  } reg_index_t;

  // Channel 0 is red, then green, blue, alpha.
  typedef logic [3:0][7:0] pixel_t;
  typedef logic [3:0][8:0] pair_t;

  localparam int LINE_W = $bits(pair_t);

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    pair_t             wdata;
  } ram_cmd_t;

  typedef struct packed {
    logic  emit;
    logic  use_line;
    logic  final_pixel;
    pair_t pair;
  } stage_info_t;

  typedef struct packed {
    logic s1_valid;
    logic s1_emit;
    logic s1_use_line;
  } stage_status_t;

endpackage

### design/rgbds_if.sv
// Handshake channels of the downsampler: source pixels in, reduced pixels out.
// Standalone; no package needed.
interface rgbds_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] alpha_in;

  modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
  modport sink (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface rgbds_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;
  logic       final_pixel;

  modport source (output valid, red_out, green_out, blue_out, alpha_out, final_pixel,
                  input ready);
  modport sink (input valid, red_out, green_out, blue_out, alpha_out, final_pixel,
                output ready);
endinterface

### design/rgbds_line_ram.sv
// Generic simple dual-port RAM, one write and one read port, registered read.
// Standalone; no package needed.
module rgbds_line_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 36
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/rgbds_scan.sv
// Raster scan of the source image: position counters, the held even pixel,
// horizontal pair sums and line-store commands. Depends on rgbds_pkg.
module rgbds_scan (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  rgbds_pkg::pixel_t          pixel,
  input  logic [rgbds_pkg::REG_W-1:0] source_width,
  input  logic [rgbds_pkg::REG_W-1:0] source_height,
  output rgbds_pkg::ram_cmd_t        ram_cmd,
  output rgbds_pkg::stage_info_t     info
);
  import rgbds_pkg::*;

  logic [COL_W-1:0]  column_count, column_count_next;
  logic [ROW_W-1:0]  row_count, row_count_next;
  pixel_t            held_even_pixel;

  logic [WID_W-1:0]  w;
  logic [HGT_W-1:0]  h;
  logic [COL_W-1:0]  dw;
  logic [ROW_W-1:0]  dh;
  logic              w_one, h_one;
  logic              have_pair;
  logic [ADDR_W-1:0] x;
  logic [ROW_W-2:0]  y;
  pair_t             pair;
  logic              row_even_ok, row_odd_ok;

  always_comb begin
    if (source_width == '0) begin
      w = WID_W'(1);
    end else if (32'(source_width) > MAX_SOURCE_WIDTH) begin
      w = WID_W'(MAX_SOURCE_WIDTH);
    end else begin
      w = WID_W'(source_width);
    end
    if (source_height == '0) begin
      h = HGT_W'(1);
    end else if (32'(source_height) > HEIGHT_LIMIT) begin
      h = HGT_W'(HEIGHT_LIMIT);
    end else begin
      h = HGT_W'(source_height);
    end
  end

  assign w_one = (w == WID_W'(1));
  assign h_one = (h == HGT_W'(1));
  assign dw    = w_one ? COL_W'(1) : w[WID_W-1:1];
  assign dh    = h_one ? ROW_W'(1) : h[HGT_W-1:1];

  always_comb begin
    if (w_one) begin
      have_pair = (column_count == '0);
      x         = '0;
      for (int k = 0; k < 4; k++) pair[k] = {pixel[k], 1'b0};
    end else begin
      have_pair = column_count[0] &&
                  ({1'b0, column_count} < {w[WID_W-1:1], 1'b0});
      x         = column_count[COL_W-1:1];
      for (int k = 0; k < 4; k++) pair[k] = {1'b0, held_even_pixel[k]} + {1'b0, pixel[k]};
    end
  end

  assign row_even_ok = !h_one && !row_count[0] && ({1'b0, row_count} < {h[HGT_W-1:1], 1'b0});
  assign row_odd_ok  = !h_one && row_count[0] && ({1'b0, row_count} < {h[HGT_W-1:1], 1'b0});
  assign y           = h_one ? '0 : row_count[ROW_W-1:1];

  // Even rows park the pair sum in the line store; odd rows read it back.
  assign ram_cmd.wr_en = accept && have_pair && row_even_ok;
  assign ram_cmd.rd_en = accept && have_pair && row_odd_ok;
  assign ram_cmd.addr  = x;
  assign ram_cmd.wdata = pair;

  assign info.emit        = have_pair && ((h_one && row_count == '0) || row_odd_ok);
  assign info.use_line    = !h_one;
  assign info.final_pixel = ({1'b0, x} == dw - COL_W'(1)) && ({1'b0, y} == dh - ROW_W'(1));
  assign info.pair        = pair;

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if ({1'b0, column_count} >= w - WID_W'(1)) begin
      column_count_next = '0;
      row_count_next    = ({1'b0, row_count} >= h - HGT_W'(1)) ? '0
                                                               : row_count + ROW_W'(1);
    end else begin
      column_count_next = column_count + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= '0;
      row_count       <= '0;
      held_even_pixel <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      if (!w_one && !column_count[0] &&
          ({1'b0, column_count} < {w[WID_W-1:1], 1'b0})) begin
        held_even_pixel <= pixel;
      end
    end
  end

endmodule

### design/rgbds_reduce.sv
// Second stage and output register: adds the stored pair sums, rounds the
// mean and hands results out through the output channel. Depends on rgbds_pkg.
module rgbds_reduce (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  rgbds_pkg::stage_info_t   info,
  input  rgbds_pkg::pair_t         line_data,
  output logic                     in_free,
  output rgbds_pkg::stage_status_t status,
  rgbds_res_if.source              results
);
  import rgbds_pkg::*;

  logic        s1_valid;
  stage_info_t s1;
  logic        out_valid;
  logic        adv, s1_go;
  pixel_t      mean;
  logic [9:0]  sum;

  assign adv     = !out_valid || results.ready;
  assign s1_go   = s1_valid && (!s1.emit || adv);
  assign in_free = !s1_valid || s1_go;

  always_comb begin
    sum = '0;
    for (int k = 0; k < 4; k++) begin
      sum     = s1.use_line ? ({1'b0, line_data[k]} + {1'b0, s1.pair[k]})
                            : {s1.pair[k], 1'b0};
      sum     = sum + 10'd2;
      mean[k] = sum[9:2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= info;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1.emit && adv) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1.emit && adv) begin
      results.red_out     <= mean[0];
      results.green_out   <= mean[1];
      results.blue_out    <= mean[2];
      results.alpha_out   <= mean[3];
      results.final_pixel <= s1.final_pixel;
    end
  end

  assign results.valid      = out_valid;
  assign status.s1_valid    = s1_valid;
  assign status.s1_emit     = s1.emit;
  assign status.s1_use_line = s1.use_line;

endmodule

### design/rgba8_box_downsample_2x2.sv
// Top level of the RGBA8 2x2 box downsampler: configuration registers, scan,
// line store and reduce stage. Depends on rgbds_pkg, rgbds_if and the submodules.
//
//   channel   direction  handshake      payload
//   pixels    in         valid/ready    red_in green_in blue_in alpha_in
//   results   out        valid/ready    red_out green_out blue_out alpha_out final_pixel
//   config    in         write_enable   write_index write_data (13 bits)
//
// One source pixel is taken every clock cycle while the reduce stage can take it;
// the line store, whose read and write ports share one address, carries at most one
// read or one write per pixel. A result is held in the reduce stage register and
// then loaded into the output register when the output can advance.
// Synchronous reset clears the counters, the held pixel and all valid flags and
// sets both image sides to 1; the line store is not cleared. When a finished
// result waits at the output and the next one is ready too, input stalls.
module rgba8_box_downsample_2x2 (
  input  logic                               clk,
  input  logic                               rst,
  rgbds_pix_if.sink                          pixels,
  rgbds_res_if.source                        results,
  input  logic                               write_enable,
  input  logic [rgbds_pkg::REG_INDEX_W-1:0]  write_index,
  input  logic [rgbds_pkg::REG_W-1:0]        write_data
);
  import rgbds_pkg::*;

  logic [REG_W-1:0] source_width;
  logic [REG_W-1:0] source_height;
  logic             accept;
  logic             in_free;
  pixel_t           pixel;
  ram_cmd_t         ram_cmd;
  stage_info_t      info;
  pair_t            line_data;
  stage_status_t    status;

  // New sizes take effect on the next pixel; the scan counters are not cleared, so a
  // column counter at or past its new limit wraps on that pixel, a row counter at the end of that line.
  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= REG_W'(1);
      source_height <= REG_W'(1);
    end else if (write_enable) begin
      case (write_index)
        REG_SOURCE_WIDTH:  source_width  <= write_data;
        REG_SOURCE_HEIGHT: source_height <= write_data;
        default: ;
      endcase
    end
  end

  assign pixel        = {pixels.alpha_in, pixels.blue_in, pixels.green_in, pixels.red_in};
  assign accept       = pixels.valid && in_free;
  assign pixels.ready = in_free;

  // The scan stage turns each pixel into a horizontal pair sum and, on odd
  // rows, issues the read of the pair sum left by the even row above.
  rgbds_scan u_scan (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .pixel         (pixel),
    .source_width  (source_width),
    .source_height (source_height),
    .ram_cmd       (ram_cmd),
    .info          (info)
  );

  // Half-width line store of pair sums. A write and a later read of the same
  // entry always come from different pixels, and the read is registered after
  // the write has landed, so no forwarding is needed.
  rgbds_line_ram #(
    .DEPTH (LINE_DEPTH),
    .WIDTH (LINE_W)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (ram_cmd.wr_en),
    .wr_addr (ram_cmd.addr),
    .wr_data (ram_cmd.wdata),
    .rd_en   (ram_cmd.rd_en),
    .rd_addr (ram_cmd.addr),
    .rd_data (line_data)
  );

  // The reduce stage holds its item while the output is stalled; since no new
  // pixel is taken then, the line-store read data holds as well.
  rgbds_reduce u_reduce (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .info      (info),
    .line_data (line_data),
    .in_free   (in_free),
    .status    (status),
    .results   (results)
  );

`ifndef SYNTHESIS
  a_one_port_access: assert property (@(posedge clk) disable iff (rst)
    !(ram_cmd.wr_en && ram_cmd.rd_en))
    else $error("line store read and write in the same cycle");

  a_read_feeds_stage: assert property (@(posedge clk) disable iff (rst)
    ram_cmd.rd_en |=> (status.s1_valid && status.s1_emit && status.s1_use_line))
    else $error("line store read without an emitting item behind it");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.ready && status.s1_valid && status.s1_emit) |-> !pixels.ready)
    else $error("input taken while a result is blocked");
`endif

endmodule
